// ===== src/ccrf_pkg.sv =====
// ============================================================================
// ccrf_pkg
// Shared types, constants and the CRC-16 byte step for the command framer.
// ============================================================================
package ccrf_pkg;

    // Response framing limits.
    localparam int MAX_COUNT = 40;
    localparam int MIN_COUNT = 3;
    localparam int BUF_DEPTH = MAX_COUNT - MIN_COUNT;
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = 6;
    localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SEQ_W     = CNT_W;
    localparam int SEL_W     = 3;

    // CRC and frame constants.
    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [7:0]  WORD_ADDR = 8'h03;
    localparam logic [7:0]  CMD_COUNT = 8'h07;

    // Command frame byte positions.
    localparam logic [SEL_W-1:0] FB_WADDR  = 3'd0;
    localparam logic [SEL_W-1:0] FB_COUNT  = 3'd1;
    localparam logic [SEL_W-1:0] FB_OPCODE = 3'd2;
    localparam logic [SEL_W-1:0] FB_PARAM1 = 3'd3;
    localparam logic [SEL_W-1:0] FB_P2_LO  = 3'd4;
    localparam logic [SEL_W-1:0] FB_P2_HI  = 3'd5;
    localparam logic [SEL_W-1:0] FB_CRC_LO = 3'd6;
    localparam logic [SEL_W-1:0] FB_CRC_HI = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [1:0] ST_CRC       = 2'd2;
    localparam logic [1:0] ST_LEN       = 2'd3;

    // Input request payload.
    typedef struct packed {
        logic        func;
        logic [7:0]  opcode;
        logic [7:0]  param1;
        logic [15:0] param2;
        logic [7:0]  rx_byte;
        logic        rx_first;
    } ccrf_req_t;

    // Result payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic       has_byte;
        logic [1:0] status;
        logic       last;
    } ccrf_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             take_req;
        logic             emit_frame;
        logic             emit_dump;
        logic             emit_status;
        logic [SEL_W-1:0] frame_sel;
        logic [ADDR_W-1:0] rd_addr;
        logic             dump_last;
    } ccrf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             out_free;
        logic             is_frame;
        logic             rx_single;
        logic             rx_dump;
        logic [CNT_W-1:0] dump_n;
    } ccrf_stat_t;

    // One byte through the CRC register, data taken LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            fb  = data[k] ^ crc[15];
            crc = {crc[14:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// ===== src/ccrf_ram.sv =====
// ============================================================================
// ccrf_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ccrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ccrf_datapath.sv =====
// ============================================================================
// ccrf_datapath
// Request decode, CRC register, response bookkeeping, data buffer and the
// output register.
// ============================================================================
module ccrf_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [5:0]             cfg_wr_data,
    input  ccrf_pkg::ccrf_req_t    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ccrf_pkg::ccrf_rsp_t    out_data,
    input  ccrf_pkg::ccrf_cmd_t    cmd,
    output ccrf_pkg::ccrf_stat_t   stat
);
    import ccrf_pkg::*;

    logic [LEN_W-1:0] expected_len_reg;
    logic [7:0]       opcode_reg;
    logic [7:0]       param1_reg;
    logic [15:0]      param2_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       crc_low_reg;
    logic [CNT_W-1:0] frame_count_reg;
    logic [CNT_W-1:0] byte_index_reg;
    logic             receiving_reg;
    logic [1:0]       status_reg;
    logic             out_valid_reg;
    ccrf_rsp_t        out_data_reg;

    logic [CNT_W:0]   idx_p2;
    logic [CNT_W:0]   fc_ext;
    logic             mid_byte;
    logic             crc_lo_byte;
    logic             rsp_close;
    logic [CNT_W-1:0] data_n;
    logic             crc_bad;
    logic             len_bad;
    logic             bad_count;
    logic [1:0]       rx_status;
    logic             buf_wr;
    logic [CNT_W-1:0] buf_wr_pos;
    logic [7:0]       buf_rd_data;
    logic [7:0]       frame_byte;
    logic             frame_crc_step;
    logic             out_free;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_len_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            expected_len_reg <= cfg_wr_data;
        end
    end

    // Classify the response byte on the input against the open response.
    assign idx_p2      = {1'b0, byte_index_reg} + (CNT_W + 1)'(2);
    assign fc_ext      = {1'b0, frame_count_reg};
    assign mid_byte    = idx_p2 < fc_ext;
    assign crc_lo_byte = idx_p2 == fc_ext;
    assign rsp_close   = in_data.func && !in_data.rx_first && receiving_reg
                         && !mid_byte && !crc_lo_byte;
    assign data_n      = frame_count_reg - CNT_W'(MIN_COUNT);
    assign crc_bad     = {in_data.rx_byte, crc_low_reg} != crc_reg;
    assign len_bad     = CMP_W'(data_n) != CMP_W'(expected_len_reg);
    assign bad_count   = (in_data.rx_byte < 8'(MIN_COUNT))
                         || (in_data.rx_byte > 8'(MAX_COUNT));

    always_comb
    begin
        if (in_data.rx_first)
        begin
            rx_status = ST_BAD_COUNT;
        end
        else if (crc_bad)
        begin
            rx_status = ST_CRC;
        end
        else if (len_bad)
        begin
            rx_status = ST_LEN;
        end
        else
        begin
            rx_status = ST_OK;
        end
    end

    // Status toward the controller.
    assign out_free       = !out_valid_reg || !out_stall;
    assign stat.out_free  = out_free;
    assign stat.is_frame  = !in_data.func;
    assign stat.rx_single = in_data.func && (in_data.rx_first ? bad_count
                            : (rsp_close && (crc_bad || len_bad || data_n == '0)));
    assign stat.rx_dump   = rsp_close && !crc_bad && !len_bad && (data_n != '0);
    assign stat.dump_n    = data_n;

    // Data bytes of an open response go into the buffer.
    assign buf_wr     = cmd.take_req && in_data.func && !in_data.rx_first
                        && receiving_reg && mid_byte;
    assign buf_wr_pos = byte_index_reg - CNT_W'(1);

    ccrf_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr),
        .wr_addr (buf_wr_pos[ADDR_W-1:0]),
        .wr_data (in_data.rx_byte),
        .rd_addr (cmd.rd_addr),
        .rd_data (buf_rd_data)
    );

    // Command frame byte selection.
    always_comb
    begin
        frame_crc_step = 1'b1;
        case (cmd.frame_sel)
            FB_WADDR:
            begin
                frame_byte     = WORD_ADDR;
                frame_crc_step = 1'b0;
            end
            FB_COUNT:  frame_byte = CMD_COUNT;
            FB_OPCODE: frame_byte = opcode_reg;
            FB_PARAM1: frame_byte = param1_reg;
            FB_P2_LO:  frame_byte = param2_reg[7:0];
            FB_P2_HI:  frame_byte = param2_reg[15:8];
            FB_CRC_LO:
            begin
                frame_byte     = crc_reg[7:0];
                frame_crc_step = 1'b0;
            end
            default:
            begin
                frame_byte     = crc_reg[15:8];
                frame_crc_step = 1'b0;
            end
        endcase
    end

    // Request capture, response tracking and the CRC register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg   <= 1'b0;
            crc_reg         <= '0;
            crc_low_reg     <= '0;
            frame_count_reg <= '0;
            byte_index_reg  <= '0;
            opcode_reg      <= '0;
            param1_reg      <= '0;
            param2_reg      <= '0;
            status_reg      <= ST_OK;
        end
        else if (cmd.take_req)
        begin
            status_reg <= rx_status;
            if (!in_data.func)
            begin
                opcode_reg    <= in_data.opcode;
                param1_reg    <= in_data.param1;
                param2_reg    <= in_data.param2;
                receiving_reg <= 1'b0;
                crc_reg       <= '0;
            end
            else if (in_data.rx_first)
            begin
                if (bad_count)
                begin
                    receiving_reg <= 1'b0;
                end
                else
                begin
                    receiving_reg   <= 1'b1;
                    frame_count_reg <= in_data.rx_byte[CNT_W-1:0];
                    byte_index_reg  <= CNT_W'(1);
                    crc_reg         <= crc_byte(16'h0000, in_data.rx_byte);
                end
            end
            else if (receiving_reg)
            begin
                if (mid_byte)
                begin
                    crc_reg        <= crc_byte(crc_reg, in_data.rx_byte);
                    byte_index_reg <= byte_index_reg + CNT_W'(1);
                end
                else if (crc_lo_byte)
                begin
                    crc_low_reg    <= in_data.rx_byte;
                    byte_index_reg <= byte_index_reg + CNT_W'(1);
                end
                else
                begin
                    receiving_reg <= 1'b0;
                end
            end
        end
        else if (cmd.emit_frame && frame_crc_step)
        begin
            crc_reg <= crc_byte(crc_reg, frame_byte);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_frame || cmd.emit_dump || cmd.emit_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_frame)
        begin
            out_data_reg.out_byte <= frame_byte;
            out_data_reg.kind     <= 1'b0;
            out_data_reg.has_byte <= 1'b1;
            out_data_reg.status   <= ST_OK;
            out_data_reg.last     <= cmd.frame_sel == FB_CRC_HI;
        end
        else if (cmd.emit_dump)
        begin
            out_data_reg.out_byte <= buf_rd_data;
            out_data_reg.kind     <= 1'b1;
            out_data_reg.has_byte <= 1'b1;
            out_data_reg.status   <= ST_OK;
            out_data_reg.last     <= cmd.dump_last;
        end
        else if (cmd.emit_status)
        begin
            out_data_reg.out_byte <= 8'h00;
            out_data_reg.kind     <= 1'b1;
            out_data_reg.has_byte <= 1'b0;
            out_data_reg.status   <= status_reg;
            out_data_reg.last     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/ccrf_ctrl.sv =====
// ============================================================================
// ccrf_ctrl
// Sequencer that takes requests and steps out frame bytes, buffered response
// bytes or a single status result.
// ============================================================================
module ccrf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output ccrf_pkg::ccrf_cmd_t  cmd,
    input  ccrf_pkg::ccrf_stat_t stat
);
    import ccrf_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_FRAME     = 3'd1;
    localparam logic [2:0] S_STATUS    = 3'd2;
    localparam logic [2:0] S_DUMP_RD   = 3'd3;
    localparam logic [2:0] S_DUMP_EMIT = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic [SEQ_W-1:0] n_reg;
    logic [SEQ_W-1:0] n_next;
    logic             dump_last;

    assign dump_last = (seq_reg + SEQ_W'(1)) == n_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        seq_next        = seq_reg;
        n_next          = n_reg;
        cmd.take_req    = 1'b0;
        cmd.emit_frame  = 1'b0;
        cmd.emit_dump   = 1'b0;
        cmd.emit_status = 1'b0;
        cmd.frame_sel   = seq_reg[SEL_W-1:0];
        cmd.rd_addr     = seq_reg[ADDR_W-1:0];
        cmd.dump_last   = dump_last;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_req = 1'b1;
                    seq_next     = '0;
                    if (stat.is_frame)
                    begin
                        state_next = S_FRAME;
                    end
                    else if (stat.rx_single)
                    begin
                        state_next = S_STATUS;
                    end
                    else if (stat.rx_dump)
                    begin
                        state_next = S_DUMP_RD;
                        n_next     = stat.dump_n;
                    end
                end
            end
            S_FRAME:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_frame = 1'b1;
                    if (seq_reg[SEL_W-1:0] == FB_CRC_HI)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        seq_next = seq_reg + SEQ_W'(1);
                    end
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_dump = 1'b1;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        seq_next   = seq_reg + SEQ_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seq_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            n_reg     <= n_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

// ===== src/crc_command_response_framer_core.sv =====
// ============================================================================
// crc_command_response_framer_core
// Command framer and response checker with CRC-16 (poly 0x8005, init 0).
// ============================================================================
// Usage:
//   A request with func 0 frames a command: eight result bytes follow (word
//   address, count, opcode, param1, param2 low and high, CRC low and high),
//   the last one flagged. A request with func 1 carries one response byte;
//   rx_first marks the count byte. Data bytes are buffered and only sent on
//   after the CRC and length checks pass; otherwise one status result is sent.
//   expected_len is written through cfg_wr_en and cfg_wr_data while idle.
// Sequencing:
//   A response byte that gives no result leaves the sequencer idle. A frame
//   request is accepted, then S_FRAME loads its bytes in order. A status result
//   is loaded from S_STATUS. A verified response emits its n data bytes, each
//   read from the buffer in S_DUMP_RD, then loaded in S_DUMP_EMIT (registered read).
// Reset:
//   rst_n clears the sequencer, the open response and expected_len; the data
//   buffer is not cleared and needs no clearing pass.
// Stall:
//   A result holds in the output register while out_stall is high, and the
//   sequencer waits; in_stall stays high until the request has been handled.
// ============================================================================
module crc_command_response_framer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [5:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  ccrf_pkg::ccrf_req_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ccrf_pkg::ccrf_rsp_t out_data
);
    import ccrf_pkg::*;

    ccrf_cmd_t  cmd;
    ccrf_stat_t stat;

    // Sequencer.
    ccrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Datapath.
    ccrf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cmd         (cmd),
        .stat        (stat)
    );

`ifndef SYNTHESIS
    // A frame request keeps the input stalled while its bytes go out.
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !in_data.func) |=> in_stall)
        else $error("frame request did not stall the input");

    // At most one result is loaded per cycle.
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_frame, cmd.emit_dump, cmd.emit_status}))
        else $error("more than one result loaded in a cycle");

    // A result is loaded only when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_frame || cmd.emit_dump || cmd.emit_status) |-> stat.out_free)
        else $error("result loaded over a stalled result");

    // Command bytes always carry a byte and an ok status.
    a_cmd_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.kind) |-> (out_data.has_byte && out_data.status == ST_OK))
        else $error("command byte without data or with error status");
`endif

endmodule
